// File: rtl/cthm_pkg.sv
// Shared widths, payload types and the saturating adder for the tower hit merger.
`timescale 1ns / 1ps
`default_nettype none
package cthm_pkg;

	localparam int CAL_W      = 2;
	localparam int ETA_W      = 8;
	localparam int PHI_W      = 10;
	localparam int E_W        = 24;
	localparam int SUM_W      = 32;
	localparam int NUM_REGS   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam logic [PHI_W-1:0] HALF_RESET = PHI_W'(16);

	localparam int MAX_GROUPS_DEF = 64;
	localparam int NUM_CALS_DEF   = 4;

	// Hit token travelling down the chain.
	typedef struct packed {
		logic             vld;   // a hit occupies this slot
		logic             live;  // not yet absorbed by any cell
		logic             last;  // final hit of the event
		logic [CAL_W-1:0] cal;
		logic [ETA_W-1:0] eta;
		logic             upper;
		logic [E_W-1:0]   em;
		logic [E_W-1:0]   had;
		logic [E_W-1:0]   mn;
	} tok_t;

	// Group held by one cell.
	typedef struct packed {
		logic             valid;
		logic [CAL_W-1:0] cal;
		logic [ETA_W-1:0] eta;
		logic             upper;
		logic [SUM_W-1:0] em_sum;
		logic [SUM_W-1:0] had_sum;
		logic [SUM_W-1:0] min_sum;
	} grp_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [E_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {{(SUM_W-E_W+1){1'b0}}, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/cthm_if.sv
// Valid/ready channel interfaces for hits, merged groups and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface cthm_hit_if;
	logic                          valid;
	logic                          ready;
	logic [cthm_pkg::CAL_W-1:0]    cal_number;
	logic [cthm_pkg::ETA_W-1:0]    eta_index;
	logic [cthm_pkg::PHI_W-1:0]    phi_index;
	logic [cthm_pkg::E_W-1:0]      em_energy;
	logic [cthm_pkg::E_W-1:0]      had_energy;
	logic [cthm_pkg::E_W-1:0]      min_energy;
	logic                          last_hit;
	modport source (output valid, cal_number, eta_index, phi_index, em_energy,
		had_energy, min_energy, last_hit, input ready);
	modport sink (input valid, cal_number, eta_index, phi_index, em_energy,
		had_energy, min_energy, last_hit, output ready);
endinterface

interface cthm_grp_if;
	logic                          valid;
	logic                          ready;
	logic [cthm_pkg::CAL_W-1:0]    out_cal;
	logic [cthm_pkg::ETA_W-1:0]    out_eta;
	logic [cthm_pkg::PHI_W-1:0]    phi_start;
	logic [cthm_pkg::SUM_W-1:0]    em_sum;
	logic [cthm_pkg::SUM_W-1:0]    had_sum;
	logic [cthm_pkg::SUM_W-1:0]    min_sum;
	logic                          overflow;
	logic                          last_group;
	modport source (output valid, out_cal, out_eta, phi_start, em_sum, had_sum,
		min_sum, overflow, last_group, input ready);
	modport sink (input valid, out_cal, out_eta, phi_start, em_sum, had_sum,
		min_sum, overflow, last_group, output ready);
endinterface

interface cthm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [cthm_pkg::CFG_IDX_W-1:0]    index;
	logic [cthm_pkg::PHI_W-1:0]        data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/cthm_cell.sv
// One group cell: matches or claims the passing hit token, shifts toward the output at readout.
`timescale 1ns / 1ps
`default_nettype none
module cthm_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cthm_pkg::tok_t tok_in,
	output cthm_pkg::tok_t      tok_out,
	input  wire logic           shift,
	input  wire cthm_pkg::grp_t grp_right,
	output cthm_pkg::grp_t      grp
);

	cthm_pkg::tok_t tok_q;
	cthm_pkg::tok_t tok_nxt;
	cthm_pkg::grp_t grp_q;
	logic           match;
	logic           claim;

	assign match = tok_in.live && grp_q.valid && (grp_q.cal == tok_in.cal) &&
		(grp_q.eta == tok_in.eta) && (grp_q.upper == tok_in.upper);
	// cells fill in order, so the first empty cell a hit reaches is the next free slot
	assign claim = tok_in.live && !grp_q.valid;

	// Pass the token on; it stays live only if this cell neither joined nor claimed it.
	always_comb begin
		tok_nxt      = tok_in;
		tok_nxt.live = tok_in.live && !match && !claim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			grp_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (shift) begin
				grp_q <= grp_right;
			end else if (match) begin
				grp_q.em_sum  <= cthm_pkg::sat_add(grp_q.em_sum, tok_in.em);
				grp_q.had_sum <= cthm_pkg::sat_add(grp_q.had_sum, tok_in.had);
				grp_q.min_sum <= cthm_pkg::sat_add(grp_q.min_sum, tok_in.mn);
			end else if (claim) begin
				grp_q.valid   <= 1'b1;
				grp_q.cal     <= tok_in.cal;
				grp_q.eta     <= tok_in.eta;
				grp_q.upper   <= tok_in.upper;
				grp_q.em_sum  <= {{(cthm_pkg::SUM_W-cthm_pkg::E_W){1'b0}}, tok_in.em};
				grp_q.had_sum <= {{(cthm_pkg::SUM_W-cthm_pkg::E_W){1'b0}}, tok_in.had};
				grp_q.min_sum <= {{(cthm_pkg::SUM_W-cthm_pkg::E_W){1'b0}}, tok_in.mn};
			end
		end
	end

	assign tok_out = tok_q;
	assign grp     = grp_q;

endmodule
`default_nettype wire

// File: rtl/calorimeter_tower_hit_merger_core.sv
// Top level of the calorimeter tower hit merger: input stage, cell chain and readout control.
//
// Hits are merged into groups keyed by calorimeter, eta and phi half (upper when phi is at or
// above the calorimeter's half count; calorimeters at or beyond NUM_CALS count as upper).
// The groups live in a chain of MAX_GROUPS cells; each hit is registered once and then walks
// the chain one cell per cycle, joining the first cell with the same key or claiming the
// first empty cell, so a new hit is taken every cycle while an event is being collected.
// A hit that leaves the end of the chain unabsorbed is dropped and sets the overflow flag.
// After the hit marked last is taken, input stalls while that hit walks the whole chain; then
// the groups shift out of the head cell in order of first appearance at one per cycle (as the
// sink allows), the final one with last_group set, and the empty chain and cleared overflow
// flag are ready for the next event. Register writes are taken at any time (one per cycle) but
// must only be made between events; phi_start uses the half count in force at readout.
`timescale 1ns / 1ps
`default_nettype none
module calorimeter_tower_hit_merger_core #(
	parameter int MAX_GROUPS = cthm_pkg::MAX_GROUPS_DEF,
	parameter int NUM_CALS   = cthm_pkg::NUM_CALS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cthm_hit_if.sink    hits,
	cthm_grp_if.source  groups,
	cthm_cfg_if.sink    cfg
);

	typedef enum logic [1:0] {
		ACCEPT,
		DRAIN,
		EMIT
	} state_t;

	state_t                        state_q;
	logic                          overflow_q;
	logic [cthm_pkg::PHI_W-1:0]    half_q [cthm_pkg::NUM_REGS];
	cthm_pkg::tok_t                hit_s1;
	cthm_pkg::tok_t                tok_chain [MAX_GROUPS+1];
	cthm_pkg::grp_t                grp_chain [MAX_GROUPS+1];
	logic [MAX_GROUPS-1:0]         valid_vec;
	logic                          hit_xfer;
	logic                          grp_xfer;
	logic                          shift;
	cthm_pkg::tok_t                tail;

	// Half count for a calorimeter; calorimeters at or beyond NUM_CALS read as zero.
	function automatic logic [cthm_pkg::PHI_W-1:0] half_of(
		input logic [cthm_pkg::CAL_W-1:0] cal,
		input logic [cthm_pkg::PHI_W-1:0] h0,
		input logic [cthm_pkg::PHI_W-1:0] h1,
		input logic [cthm_pkg::PHI_W-1:0] h2,
		input logic [cthm_pkg::PHI_W-1:0] h3);
		logic [cthm_pkg::PHI_W-1:0] h;
		unique case (cal)
			2'd0:    h = h0;
			2'd1:    h = h1;
			2'd2:    h = h2;
			default: h = h3;
		endcase
		return (32'(cal) < NUM_CALS) ? h : '0;
	endfunction

	// Configuration: always ready, store the written half count.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cthm_pkg::NUM_REGS; i++) begin
				half_q[i] <= cthm_pkg::HALF_RESET;
			end
		end else if (cfg.valid && cfg.ready) begin
			half_q[cfg.index] <= cfg.data;
		end
	end

	// Input stage: take a hit each cycle while collecting, resolve its phi half here.
	assign hits.ready = (state_q == ACCEPT);
	assign hit_xfer   = hits.valid && hits.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= '0;
		end else begin
			hit_s1.vld   <= hit_xfer;
			hit_s1.live  <= hit_xfer;
			hit_s1.last  <= hit_xfer && hits.last_hit;
			hit_s1.cal   <= hits.cal_number;
			hit_s1.eta   <= hits.eta_index;
			hit_s1.upper <= hits.phi_index >= half_of(hits.cal_number, half_q[0],
				half_q[1], half_q[2], half_q[3]);
			hit_s1.em    <= hits.em_energy;
			hit_s1.had   <= hits.had_energy;
			hit_s1.mn    <= hits.min_energy;
		end
	end

	// Cell chain: tokens flow away from the head, groups shift toward it at readout.
	assign tok_chain[0]          = hit_s1;
	assign grp_chain[MAX_GROUPS] = '0;

	for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
		cthm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_in    (tok_chain[g]),
			.tok_out   (tok_chain[g+1]),
			.shift     (shift),
			.grp_right (grp_chain[g+1]),
			.grp       (grp_chain[g])
		);
		assign valid_vec[g] = grp_chain[g].valid;
	end

	assign tail = tok_chain[MAX_GROUPS];

	// Readout from the head cell; the group behind it being empty marks the final one.
	assign groups.valid      = (state_q == EMIT) && grp_chain[0].valid;
	assign groups.out_cal    = grp_chain[0].cal;
	assign groups.out_eta    = grp_chain[0].eta;
	assign groups.phi_start  = grp_chain[0].upper ? half_of(grp_chain[0].cal, half_q[0],
		half_q[1], half_q[2], half_q[3]) : '0;
	assign groups.em_sum     = grp_chain[0].em_sum;
	assign groups.had_sum    = grp_chain[0].had_sum;
	assign groups.min_sum    = grp_chain[0].min_sum;
	assign groups.overflow   = overflow_q;
	assign groups.last_group = !grp_chain[1].valid;

	assign grp_xfer = groups.valid && groups.ready;
	assign shift    = grp_xfer;

	// Control: collect, wait for the last hit to clear the chain, emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ACCEPT;
			overflow_q <= 1'b0;
		end else begin
			if (tail.vld && tail.live) begin
				overflow_q <= 1'b1;
			end
			unique case (state_q)
				ACCEPT: begin
					if (hit_xfer && hits.last_hit) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (tail.vld && tail.last) begin
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (!grp_chain[0].valid || (grp_xfer && groups.last_group)) begin
						state_q    <= ACCEPT;
						overflow_q <= 1'b0;
					end
				end
				default: state_q <= ACCEPT;
			endcase
		end
	end

	// Occupied cells always form an unbroken run from the head.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + {{MAX_GROUPS{1'b0}}, 1'b1}))
		else $error("group cells not contiguous");

	// No hit token sits in the input stage or at the end of the chain while groups are emitted.
	a_no_tok_at_emit: assert property (@(posedge clk) disable iff (!arst_n)
		groups.valid |-> (!hit_s1.vld && !tail.vld))
		else $error("hit token in chain during readout");

	// Taking the final group ends the readout.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_xfer && groups.last_group) |=> (!groups.valid && !overflow_q))
		else $error("readout continued past final group");

	// Input stalls once the last hit of an event is taken.
	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_xfer && hits.last_hit) |=> !hits.ready)
		else $error("hit taken while event still draining");

endmodule
`default_nettype wire

// File: tb/calorimeter_tower_hit_merger_core_tb.sv
`timescale 1ns / 1ps
// Testbench for the tower hit merger: directed and random events checked against a group predictor.
module calorimeter_tower_hit_merger_core_tb;
	import cthm_pkg::*;

	// Table depth of the default build and the settle time after a readout: the last hit walks
	// the whole chain before the first group comes out, so allow that plus some margin.
	localparam int NUM_SLOTS        = MAX_GROUPS_DEF;
	localparam int DRAIN_CYCLES     = MAX_GROUPS_DEF + 8;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int RANDOM_HITS      = 24;
	localparam int MAX_REPORTS      = 10;
	localparam int TIMEOUT_NS       = 3_000_000;
	localparam int PHI_TOP          = (1 << PHI_W) - 1;
	localparam logic [E_W-1:0] E_MAX = {E_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_PHI_CAL0,
		REG_HALF_PHI_CAL1,
		REG_HALF_PHI_CAL2,
		REG_HALF_PHI_CAL3
	} half_reg_e;

	typedef struct {
		logic [CAL_W-1:0] cal;
		logic [ETA_W-1:0] eta;
		logic [PHI_W-1:0] phi;
		logic [E_W-1:0]   em;
		logic [E_W-1:0]   had;
		logic [E_W-1:0]   mn;
		bit               last;
	} hit_rec_t;

	typedef struct {
		logic [CAL_W-1:0] cal;
		logic [ETA_W-1:0] eta;
		bit               upper;
		logic [SUM_W-1:0] em;
		logic [SUM_W-1:0] had;
		logic [SUM_W-1:0] mn;
	} slot_t;

	typedef struct {
		logic [CAL_W-1:0] cal;
		logic [ETA_W-1:0] eta;
		logic [PHI_W-1:0] phi_start;
		logic [SUM_W-1:0] em;
		logic [SUM_W-1:0] had;
		logic [SUM_W-1:0] mn;
		logic             overflow;
		logic             last_group;
	} group_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	cthm_hit_if hit_ch ();
	cthm_grp_if grp_ch ();
	cthm_cfg_if cfg_ch ();

	calorimeter_tower_hit_merger_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hits   (hit_ch),
		.groups (grp_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: the group table, the sticky drop flag and the half counts in force.
	slot_t            slots [NUM_SLOTS];
	int               slot_count;
	bit               dropped_seen;
	logic [PHI_W-1:0] half_phi [NUM_REGS];
	group_rec_t       pending_groups [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hits_taken;
	int events_closed;
	int groups_checked;
	int mismatch_count;
	bit sink_held = 1'b0;
	event start_sink_hold;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [SUM_W-1:0] clip_add(input logic [SUM_W-1:0] acc,
		input logic [E_W-1:0] e);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + (SUM_W + 1)'(e);
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	// Merge one accepted hit into the table; on the closing hit, queue one group per slot in
	// order of first appearance and clear the table and the drop flag.
	function automatic void absorb_hit(input hit_rec_t h);
		bit         upper;
		bit         found;
		int         i;
		group_rec_t g;
		upper = (h.phi >= half_phi[h.cal]);
		found = 1'b0;
		for (i = 0; i < slot_count && !found; i++) begin
			if (slots[i].cal == h.cal && slots[i].eta == h.eta && slots[i].upper == upper) begin
				slots[i].em  = clip_add(slots[i].em, h.em);
				slots[i].had = clip_add(slots[i].had, h.had);
				slots[i].mn  = clip_add(slots[i].mn, h.mn);
				found = 1'b1;
			end
		end
		if (!found) begin
			if (slot_count < NUM_SLOTS) begin
				slots[slot_count] = '{h.cal, h.eta, upper, SUM_W'(h.em), SUM_W'(h.had),
					SUM_W'(h.mn)};
				slot_count++;
			end else begin
				dropped_seen = 1'b1;
			end
		end
		if (h.last) begin
			for (i = 0; i < slot_count; i++) begin
				g.cal        = slots[i].cal;
				g.eta        = slots[i].eta;
				g.phi_start  = slots[i].upper ? half_phi[slots[i].cal] : '0;
				g.em         = slots[i].em;
				g.had        = slots[i].had;
				g.mn         = slots[i].mn;
				g.overflow   = dropped_seen;
				g.last_group = (i == slot_count - 1);
				pending_groups.push_back(g);
			end
			slot_count   = 0;
			dropped_seen = 1'b0;
			events_closed++;
		end
	endfunction

	function automatic hit_rec_t make_hit(input int cal, input int eta, input int phi,
		input logic [E_W-1:0] em, input logic [E_W-1:0] had, input logic [E_W-1:0] mn,
		input bit last);
		hit_rec_t h;
		h.cal  = CAL_W'(cal);
		h.eta  = ETA_W'(eta);
		h.phi  = PHI_W'(phi);
		h.em   = em;
		h.had  = had;
		h.mn   = mn;
		h.last = last;
		return h;
	endfunction

	function automatic logic [E_W-1:0] random_energy();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return E_MAX;
		if (r < 20)
			return '0;
		return E_W'($urandom());
	endfunction

	// Keys drawn mostly from a few eta rows and, half the time, at phi values near the half
	// boundary, so that hits merge often and land on both sides of the split.
	function automatic hit_rec_t random_hit(input bit closes);
		hit_rec_t h;
		int       p;
		int       d;
		h.cal = CAL_W'($urandom_range(3));
		h.eta = ($urandom_range(99) < 70) ? ETA_W'($urandom_range(3)) : ETA_W'($urandom());
		if ($urandom_range(99) < 50) begin
			d = $urandom_range(4);
			p = int'(half_phi[h.cal]) + d - 2;
			h.phi = PHI_W'((p < 0) ? 0 : ((p > PHI_TOP) ? PHI_TOP : p));
		end else begin
			h.phi = PHI_W'($urandom());
		end
		h.em   = random_energy();
		h.had  = random_energy();
		h.mn   = random_energy();
		h.last = closes;
		return h;
	endfunction

	function automatic logic [PHI_W-1:0] random_half();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 30)
			return PHI_W'(512);
		if (r < 40)
			return PHI_W'(PHI_TOP);
		if (r < 55)
			return HALF_RESET;
		return PHI_W'($urandom());
	endfunction

	// Offer one hit, idling first at the sender's rate, and hold it until the transfer.
	// Valid stays high on return so back-to-back hits need no extra assignment.
	task automatic send_hit(input hit_rec_t h);
		while ($urandom_range(99) < send_idle_pct) begin
			hit_ch.valid <= 1'b0;
			@(posedge clk);
		end
		hit_ch.valid      <= 1'b1;
		hit_ch.cal_number <= h.cal;
		hit_ch.eta_index  <= h.eta;
		hit_ch.phi_index  <= h.phi;
		hit_ch.em_energy  <= h.em;
		hit_ch.had_energy <= h.had;
		hit_ch.min_energy <= h.mn;
		hit_ch.last_hit   <= h.last;
		@(posedge clk);
		while (hit_ch.ready !== 1'b1)
			@(posedge clk);
		absorb_hit(h);
		hits_taken++;
	endtask

	// Drop valid after the final hit of a test and let the channel go idle before anything
	// else drives it.
	task automatic idle_sender();
		hit_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every queued group has come out, then let the chain settle.
	task automatic wait_quiet();
		while (pending_groups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four half counts back to back; only called with the block idle.
	task automatic load_halves(input logic [PHI_W-1:0] h0, input logic [PHI_W-1:0] h1,
		input logic [PHI_W-1:0] h2, input logic [PHI_W-1:0] h3);
		logic [PHI_W-1:0] vals [NUM_REGS];
		half_reg_e        order [NUM_REGS];
		int               k;
		vals[0]  = h0;
		vals[1]  = h1;
		vals[2]  = h2;
		vals[3]  = h3;
		order[0] = REG_HALF_PHI_CAL0;
		order[1] = REG_HALF_PHI_CAL1;
		order[2] = REG_HALF_PHI_CAL2;
		order[3] = REG_HALF_PHI_CAL3;
		wait_quiet();
		for (k = 0; k < NUM_REGS; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= order[k];
			cfg_ch.data  <= vals[k];
			@(posedge clk);
			while (cfg_ch.ready !== 1'b1)
				@(posedge clk);
			half_phi[order[k]] = vals[k];
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Compare one transferred group against the oldest expectation, field by field.
	task automatic check_group();
		group_rec_t got;
		group_rec_t want;
		bit         bad;
		got.cal        = grp_ch.out_cal;
		got.eta        = grp_ch.out_eta;
		got.phi_start  = grp_ch.phi_start;
		got.em         = grp_ch.em_sum;
		got.had        = grp_ch.had_sum;
		got.mn         = grp_ch.min_sum;
		got.overflow   = grp_ch.overflow;
		got.last_group = grp_ch.last_group;
		if (pending_groups.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: group with none expected: cal=%0d eta=%0d phi_start=%0d",
					$realtime, got.cal, got.eta, got.phi_start);
		end else begin
			want = pending_groups.pop_front();
			groups_checked++;
			bad = (got.cal !== want.cal) || (got.eta !== want.eta) ||
				(got.phi_start !== want.phi_start) || (got.em !== want.em) ||
				(got.had !== want.had) || (got.mn !== want.mn) ||
				(got.overflow !== want.overflow) || (got.last_group !== want.last_group);
			if (bad) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("%0t: group mismatch", $realtime);
					$display("  expected cal=%0d eta=%0d phi_start=%0d em=%h had=%h min=%h ovf=%b last=%b",
						want.cal, want.eta, want.phi_start, want.em, want.had, want.mn,
						want.overflow, want.last_group);
					$display("  actual   cal=%0d eta=%0d phi_start=%0d em=%h had=%h min=%h ovf=%b last=%b",
						got.cal, got.eta, got.phi_start, got.em, got.had, got.mn,
						got.overflow, got.last_group);
				end
			end
		end
	endtask

	// Output side: check each transfer, then pick ready for the next cycle. The long hold
	// overrides the random idling.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && grp_ch.valid === 1'b1 && grp_ch.ready === 1'b1)
			check_group();
		grp_ch.ready <= !sink_held && ($urandom_range(99) >= recv_idle_pct);
	end

	// Long output stall, counted here so the sender keeps offering hits meanwhile.
	always begin
		@(start_sink_hold);
		sink_held <= 1'b1;
		repeat (SINK_HOLD_CYCLES) @(posedge clk);
		sink_held <= 1'b0;
	end

	// Field extremes under the reset half counts: zero and full-scale keys and energies,
	// merging across the upper half, a split at phi 15/16, and a one-hit event.
	task automatic test_reset_extremes();
		send_hit(make_hit(0, 0, 0, '0, '0, '0, 1'b0));
		send_hit(make_hit(3, 255, PHI_TOP, E_MAX, E_MAX, E_MAX, 1'b0));
		send_hit(make_hit(3, 255, 500, E_MAX, E_MAX, E_MAX, 1'b0));
		send_hit(make_hit(1, 10, 15, 24'h123456, 24'h0000ff, 24'hfedcba, 1'b0));
		send_hit(make_hit(1, 10, 16, 24'h000001, 24'h800000, 24'h555555, 1'b0));
		send_hit(make_hit(1, 10, 3, 24'haaaaaa, 24'h7fffff, 24'h000002, 1'b0));
		send_hit(make_hit(2, 128, 512, 24'h0f0f0f, 24'hf0f0f0, 24'h3c3c3c, 1'b0));
		// Closing hit joins an existing group.
		send_hit(make_hit(0, 0, 1, 24'h000010, 24'h000020, 24'h000030, 1'b1));
		// An event of a single hit.
		send_hit(make_hit(2, 85, 682, E_MAX, '0, 24'h5a5a5a, 1'b1));
		idle_sender();
	endtask

	// Half counts at zero, 512, all ones and one; phi_start follows the written value.
	task automatic test_half_extremes();
		load_halves('0, PHI_W'(512), PHI_W'(PHI_TOP), PHI_W'(1));
		send_hit(make_hit(0, 7, 0, 24'h000100, 24'h000200, 24'h000300, 1'b0));
		send_hit(make_hit(0, 7, PHI_TOP, 24'h000001, 24'h000001, 24'h000001, 1'b0));
		send_hit(make_hit(1, 7, 511, 24'h111111, 24'h222222, 24'h333333, 1'b0));
		send_hit(make_hit(1, 7, 512, 24'h444444, 24'h555555, 24'h666666, 1'b0));
		send_hit(make_hit(2, 7, PHI_TOP - 1, 24'h777777, 24'h888888, 24'h999999, 1'b0));
		send_hit(make_hit(2, 7, PHI_TOP, 24'haaaaaa, 24'hbbbbbb, 24'hcccccc, 1'b0));
		send_hit(make_hit(3, 7, 0, 24'hdddddd, 24'heeeeee, 24'hffffff, 1'b0));
		send_hit(make_hit(3, 7, 1, 24'h010203, 24'h040506, 24'h070809, 1'b0));
		send_hit(make_hit(2, 7, 0, 24'h0a0b0c, 24'h0d0e0f, 24'h101112, 1'b1));
		idle_sender();
	endtask

	// Fill every slot, then drop a new key, merge into the first slot, and close with a key
	// that is dropped too; the readout still follows. The next event must report no drop.
	task automatic test_table_full();
		int k;
		for (k = 0; k < NUM_SLOTS; k++)
			send_hit(make_hit(k % 4, k / 4, 0, random_energy(), random_energy(),
				random_energy(), 1'b0));
		send_hit(make_hit(0, 200, 0, 24'h00aaaa, 24'h00bbbb, 24'h00cccc, 1'b0));
		send_hit(make_hit(0, 0, 0, 24'h000005, 24'h000006, 24'h000007, 1'b0));
		send_hit(make_hit(1, 201, 0, 24'h0000aa, 24'h0000bb, 24'h0000cc, 1'b1));
		send_hit(make_hit(3, 3, 3, 24'h000033, 24'h000044, 24'h000055, 1'b0));
		send_hit(make_hit(3, 3, 4, 24'h000066, 24'h000077, 24'h000088, 1'b1));
		idle_sender();
	endtask

	// One idling profile: fresh half counts, then random events until enough hits went in.
	// Most events are short; some are long enough to run the table out.
	task automatic test_random_events(input int send_pct, input int recv_pct);
		int goal;
		int len;
		int r;
		int j;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		load_halves(random_half(), random_half(), random_half(), random_half());
		goal = hits_taken + RANDOM_HITS;
		while (hits_taken < goal) begin
			r = $urandom_range(99);
			if (r < 70)
				len = $urandom_range(1, 8);
			else if (r < 95)
				len = $urandom_range(9, 30);
			else
				len = $urandom_range(60, 75);
			for (j = 0; j < len; j++)
				send_hit(random_hit(j == len - 1));
		end
		idle_sender();
	endtask

	// Hold the output off for a long stretch while events keep coming, so the readout backs
	// up and the block stalls its input.
	task automatic test_output_stall();
		int e;
		int j;
		int len;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		-> start_sink_hold;
		for (e = 0; e < 4; e++) begin
			len = $urandom_range(4, 8);
			for (j = 0; j < len; j++)
				send_hit(random_hit(j == len - 1));
		end
		idle_sender();
	endtask

	initial begin
		int r;
		arst_n            <= 1'b0;
		hit_ch.valid      <= 1'b0;
		hit_ch.cal_number <= '0;
		hit_ch.eta_index  <= '0;
		hit_ch.phi_index  <= '0;
		hit_ch.em_energy  <= '0;
		hit_ch.had_energy <= '0;
		hit_ch.min_energy <= '0;
		hit_ch.last_hit   <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_HALF_PHI_CAL0;
		cfg_ch.data       <= '0;
		for (r = 0; r < NUM_REGS; r++)
			half_phi[r] = HALF_RESET;
		slot_count     = 0;
		dropped_seen   = 1'b0;
		hits_taken     = 0;
		events_closed  = 0;
		groups_checked = 0;
		mismatch_count = 0;
		send_idle_pct  = 19;
		recv_idle_pct  = 81;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_extremes();
		test_half_extremes();
		test_table_full();
		test_random_events(19, 81);
		test_random_events(81, 19);
		test_random_events(0, 0);
		test_output_stall();

		wait_quiet();
		$display("Ran %0d hits in %0d events and checked %0d merged groups (%0d mismatches).",
			hits_taken, events_closed, groups_checked, mismatch_count);
		$display("Covered full-table drops, half-count extremes and a long output stall.");
		if (mismatch_count == 0)
			$display("[calorimeter_tower_hit_merger_core] OK");
		else
			$display("[calorimeter_tower_hit_merger_core] ERROR");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d groups still expected.", pending_groups.size());
		$display("[calorimeter_tower_hit_merger_core] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
rtl/cthm_pkg.sv
rtl/cthm_if.sv
rtl/cthm_cell.sv
rtl/calorimeter_tower_hit_merger_core.sv
tb/calorimeter_tower_hit_merger_core_tb.sv
